// ===== rtl/ccse_pkg.sv =====
// ----------------------------------------------------------------------------
// ccse_pkg
// shared types, codes and lookup functions of the cell contour segment
// extractor
// ----------------------------------------------------------------------------
package ccse_pkg;

   localparam int CW = 20;
   localparam logic [CW-1:0] COORD_MAX = 20'hFFFFF;

   localparam logic [1:0] FACE_XY = 2'd0;
   localparam logic [1:0] FACE_YZ = 2'd1;
   localparam logic [1:0] FACE_ZX = 2'd2;
   localparam logic [2:0][1:0] FACE_CODES = {FACE_ZX, FACE_YZ, FACE_XY};

   typedef struct packed {
      logic       hit;
      logic [1:0] e0;
      logic [1:0] e1;
   } edge_pair_type;

   typedef struct packed {
      logic [1:0]    face;
      logic [CW-1:0] z1;
      logic [CW-1:0] y1;
      logic [CW-1:0] x1;
      logic [CW-1:0] z0;
      logic [CW-1:0] y0;
      logic [CW-1:0] x0;
   } seg_type;

   // crossed edges per inside mask
   function automatic edge_pair_type edge_lookup(input logic [3:0] mask);
      edge_pair_type p;
      p = '0;
      unique case (mask)
         4'd1, 4'd14:  p = '{hit: 1'b1, e0: 2'd0, e1: 2'd3};
         4'd2, 4'd13:  p = '{hit: 1'b1, e0: 2'd0, e1: 2'd1};
         4'd3, 4'd12:  p = '{hit: 1'b1, e0: 2'd1, e1: 2'd3};
         4'd4, 4'd11:  p = '{hit: 1'b1, e0: 2'd1, e1: 2'd2};
         4'd6, 4'd9:   p = '{hit: 1'b1, e0: 2'd0, e1: 2'd2};
         4'd7, 4'd8:   p = '{hit: 1'b1, e0: 2'd2, e1: 2'd3};
         default:      p = '0;
      endcase
      return p;
   endfunction

   // index of face corner into the seven corner densities
   // 0:000 1:100 2:110 3:010 4:011 5:001 6:101
   function automatic logic [2:0] face_corner(input logic [1:0] face, input logic [1:0] c);
      logic [2:0] idx;
      idx = 3'd0;
      unique case (face)
         FACE_XY: idx = {1'b0, c};
         FACE_YZ: begin
            unique case (c)
               2'd0:    idx = 3'd0;
               2'd1:    idx = 3'd3;
               2'd2:    idx = 3'd4;
               default: idx = 3'd5;
            endcase
         end
         FACE_ZX: begin
            unique case (c)
               2'd0:    idx = 3'd0;
               2'd1:    idx = 3'd5;
               2'd2:    idx = 3'd6;
               default: idx = 3'd1;
            endcase
         end
         default: idx = 3'd0;
      endcase
      return idx;
   endfunction

   // corner offset as {z, y, x}
   function automatic logic [2:0] corner_offset(input logic [1:0] face, input logic [1:0] c);
      logic [2:0] off;
      off = 3'b000;
      unique case (face)
         FACE_XY: begin
            unique case (c)
               2'd0:    off = 3'b000;
               2'd1:    off = 3'b001;
               2'd2:    off = 3'b011;
               default: off = 3'b010;
            endcase
         end
         FACE_YZ: begin
            unique case (c)
               2'd0:    off = 3'b000;
               2'd1:    off = 3'b010;
               2'd2:    off = 3'b110;
               default: off = 3'b100;
            endcase
         end
         FACE_ZX: begin
            unique case (c)
               2'd0:    off = 3'b000;
               2'd1:    off = 3'b100;
               2'd2:    off = 3'b101;
               default: off = 3'b001;
            endcase
         end
         default: off = 3'b000;
      endcase
      return off;
   endfunction

endpackage

// ===== rtl/cell_contour_segment_extractor_top.sv =====
// ----------------------------------------------------------------------------
// cell_contour_segment_extractor_top
// marching squares on the XY, YZ and ZX faces of one grid cell per beat,
// at most one line segment per face with interpolated endpoints
//
//   channel  dir  fields
//   req_     in   cell_x, cell_y, cell_z, seven corner densities
//   rsp_     out  segment endpoints, face in tuser, last segment in tlast
//   csr_     in   iso level write
//
// a beat may enter every cycle while req_tready is high; req_tready drops
// while segments stay in the cell buffer after the current pop. the path runs
// decode, divider stages, cell buffer, output register; a cell's segments
// leave one after another through the single result port. reset clears all
// valid bits and sets the iso level to 128. a stall on rsp_ freezes the
// pipeline once the cell buffer holds segments; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cell_contour_segment_extractor_top
   import ccse_pkg::*;
#(
   parameter int GRID_DIM  = 256,
   parameter int FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cell_x, cell_y, cell_z, corner_000, corner_100, corner_110, corner_010,
   // corner_011, corner_001, corner_101
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // seg_x0, seg_y0, seg_z0, seg_x1, seg_y1, seg_z1
   output logic [119:0] rsp_tdata,
   // face_plane
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   localparam int QW        = FRAC_BITS + 1;
   localparam int DIV_STEPS = 4;
   localparam int NSTG      = (QW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int VW        = FRAC_BITS + 10;
   localparam int SW        = (VW > CW + 1) ? VW : CW + 1;
   localparam logic [12:0] GRID_LIM = 13'(GRID_DIM - 1);

   typedef struct packed {
      logic [8:0]    rem;
      logic [7:0]    den;
      logic [QW-1:0] quot;
      logic [2:0]    off0;
      logic [2:0]    off1;
   } edge_work_type;

   typedef struct packed {
      logic [2:0][7:0]         base;
      logic [2:0]              face_ok;
      edge_work_type [5:0]     edges;
   } stage_type;

   function automatic logic [CW-1:0] edge_coord(input logic [7:0] base, input logic o0,
                                                input logic o1, input logic [QW-1:0] frac);
      logic [SW-1:0] v;
      logic [SW-1:0] fr;
      v  = SW'({1'b0, base} + 9'(o0)) << FRAC_BITS;
      fr = SW'(frac);
      if (o1 && !o0) begin
         v = v + fr;
      end else if (o0 && !o1) begin
         v = (v >= fr) ? v - fr : '0;
      end
      return (v > SW'(COORD_MAX)) ? COORD_MAX : v[CW-1:0];
   endfunction

   logic [7:0]      iso_level_ff;
   stage_type       dec;
   stage_type       pipe_in [NSTG+1];
   stage_type       pipe_ff [NSTG+1];
   logic [NSTG:0]   vld_in;
   logic [NSTG:0]   vld_ff;
   logic            adv;

   logic [2:0]      hold_mask_in;
   logic [2:0]      hold_mask_ff;
   seg_type         hold_seg_in [3];
   seg_type         hold_seg_ff [3];
   logic [2:0]      mask_after;
   logic [2:0]      pop_hot;
   logic [1:0]      pop_sel;
   logic            rsp_load;

   logic            rsp_tvalid_in;
   logic            rsp_tvalid_ff;
   logic            rsp_last_in;
   logic            rsp_last_ff;
   seg_type         rsp_seg_in;
   seg_type         rsp_seg_ff;

   // iso level register
   always_ff @(posedge clock) begin
      if (reset) begin
         iso_level_ff <= 8'd128;
      end else if (csr_wr_en) begin
         iso_level_ff <= csr_wr_data;
      end
   end

   // decode: masks, crossed edges, divider operands
   always_comb begin
      logic [6:0][7:0] corner;
      logic [3:0][7:0] val;
      logic [3:0]      mask;
      edge_pair_type   pair;
      logic [1:0]      e;
      logic [1:0]      c1;
      logic [7:0]      d0;
      logic [7:0]      d1;
      logic [7:0]      num;
      logic [7:0]      den;
      logic [1:0]      den_ok;
      logic            in_grid;
      corner  = req_tdata[79:24];
      dec     = '0;
      val     = '0;
      mask    = '0;
      den_ok  = '0;
      in_grid = ({5'b0, req_tdata[7:0]} < GRID_LIM) &&
                ({5'b0, req_tdata[15:8]} < GRID_LIM) &&
                ({5'b0, req_tdata[23:16]} < GRID_LIM);
      dec.base[0] = req_tdata[7:0];
      dec.base[1] = req_tdata[15:8];
      dec.base[2] = req_tdata[23:16];
      for (int f = 0; f < 3; f++) begin
         for (int i = 0; i < 4; i++) begin
            val[i]  = corner[face_corner(FACE_CODES[f], 2'(i))];
            mask[i] = val[i] > iso_level_ff;
         end
         pair = edge_lookup(mask);
         for (int s = 0; s < 2; s++) begin
            e   = (s == 0) ? pair.e0 : pair.e1;
            c1  = e + 2'd1;
            d0  = val[e];
            d1  = val[c1];
            num = (iso_level_ff >= d0) ? iso_level_ff - d0 : d0 - iso_level_ff;
            den = (d1 >= d0) ? d1 - d0 : d0 - d1;
            dec.edges[2*f+s].rem  = {1'b0, num};
            dec.edges[2*f+s].den  = den;
            dec.edges[2*f+s].quot = '0;
            dec.edges[2*f+s].off0 = corner_offset(FACE_CODES[f], e);
            dec.edges[2*f+s].off1 = corner_offset(FACE_CODES[f], c1);
            den_ok[s] = den != 8'd0;
         end
         dec.face_ok[f] = pair.hit && den_ok[0] && den_ok[1] && in_grid;
      end
   end

   assign pipe_in[0] = dec;

   // restoring divider, DIV_STEPS quotient bits per stage
   for (genvar st = 0; st < NSTG; st++) begin : g_div
      always_comb begin
         logic       ge;
         logic [8:0] sub;
         logic [7:0] rem8;
         pipe_in[st+1] = pipe_ff[st];
         for (int k = 0; k < 6; k++) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
               if (st * DIV_STEPS + j < QW) begin
                  ge   = pipe_in[st+1].edges[k].rem >= {1'b0, pipe_in[st+1].edges[k].den};
                  sub  = pipe_in[st+1].edges[k].rem - {1'b0, pipe_in[st+1].edges[k].den};
                  rem8 = ge ? sub[7:0] : pipe_in[st+1].edges[k].rem[7:0];
                  pipe_in[st+1].edges[k].quot = {pipe_in[st+1].edges[k].quot[QW-2:0], ge};
                  pipe_in[st+1].edges[k].rem  = {rem8, 1'b0};
               end
            end
         end
      end
   end

   assign vld_in = {vld_ff[NSTG-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int st = 0; st <= NSTG; st++) begin
            pipe_ff[st] <= pipe_in[st];
         end
      end
   end

   // endpoint coordinates into the cell buffer
   always_comb begin
      edge_work_type w0;
      edge_work_type w1;
      for (int f = 0; f < 3; f++) begin
         w0 = pipe_ff[NSTG].edges[2*f];
         w1 = pipe_ff[NSTG].edges[2*f+1];
         hold_seg_in[f].face = FACE_CODES[f];
         hold_seg_in[f].x0 = edge_coord(pipe_ff[NSTG].base[0], w0.off0[0], w0.off1[0], w0.quot);
         hold_seg_in[f].y0 = edge_coord(pipe_ff[NSTG].base[1], w0.off0[1], w0.off1[1], w0.quot);
         hold_seg_in[f].z0 = edge_coord(pipe_ff[NSTG].base[2], w0.off0[2], w0.off1[2], w0.quot);
         hold_seg_in[f].x1 = edge_coord(pipe_ff[NSTG].base[0], w1.off0[0], w1.off1[0], w1.quot);
         hold_seg_in[f].y1 = edge_coord(pipe_ff[NSTG].base[1], w1.off0[1], w1.off1[1], w1.quot);
         hold_seg_in[f].z1 = edge_coord(pipe_ff[NSTG].base[2], w1.off0[2], w1.off1[2], w1.quot);
      end
   end

   // segment pop from the cell buffer
   always_comb begin
      pop_sel = 2'd0;
      pop_hot = 3'b000;
      priority if (hold_mask_ff[0]) begin
         pop_sel = 2'd0;
         pop_hot = 3'b001;
      end else if (hold_mask_ff[1]) begin
         pop_sel = 2'd1;
         pop_hot = 3'b010;
      end else if (hold_mask_ff[2]) begin
         pop_sel = 2'd2;
         pop_hot = 3'b100;
      end else begin
         pop_sel = 2'd0;
         pop_hot = 3'b000;
      end
   end

   assign rsp_load   = !rsp_tvalid_ff || rsp_tready;
   assign mask_after = rsp_load ? (hold_mask_ff & ~pop_hot) : hold_mask_ff;
   assign adv        = mask_after == 3'b000;
   assign req_tready = adv;

   assign hold_mask_in  = adv ? (vld_ff[NSTG] ? pipe_ff[NSTG].face_ok : 3'b000) : mask_after;
   assign rsp_tvalid_in = rsp_load ? (|hold_mask_ff) : rsp_tvalid_ff;
   assign rsp_last_in   = mask_after == 3'b000;
   assign rsp_seg_in    = hold_seg_ff[pop_sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mask_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         hold_mask_ff  <= hold_mask_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int f = 0; f < 3; f++) begin
            hold_seg_ff[f] <= hold_seg_in[f];
         end
      end
      if (rsp_load) begin
         rsp_seg_ff  <= rsp_seg_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_seg_ff.face;
   assign rsp_tdata  = {rsp_seg_ff.z1, rsp_seg_ff.y1, rsp_seg_ff.x1,
                        rsp_seg_ff.z0, rsp_seg_ff.y0, rsp_seg_ff.x0};

endmodule

// ===== rtl/ccse_checker.sv =====
// ----------------------------------------------------------------------------
// ccse_checker
// port-level checks on the result channel of the segment extractor
// ----------------------------------------------------------------------------
module ccse_checker
   import ccse_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   logic       open_in;
   logic       open_ff;
   logic [1:0] face_in;
   logic [1:0] face_ff;

   // run of a cell in progress and its last face
   assign open_in = (rsp_tvalid && rsp_tready) ? !rsp_tlast : open_ff;
   assign face_in = (rsp_tvalid && rsp_tready) ? rsp_tuser : face_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         face_ff <= FACE_XY;
      end else begin
         open_ff <= open_in;
         face_ff <= face_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_face_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == FACE_XY || rsp_tuser == FACE_YZ || rsp_tuser == FACE_ZX))
      else $error("bad face code");

   a_face_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && open_ff |-> rsp_tuser > face_ff)
      else $error("faces of one cell out of order");

endmodule

bind cell_contour_segment_extractor_top ccse_checker u_ccse_checker (.*);
